>>> src/ltc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the luma threshold centroid block.
package ltc_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int POS_W     = $clog2(MAX_DIM);
	localparam int DIM_W     = 13;
	localparam int COLOR_W   = 8;
	localparam int THR_W     = 8;
	localparam int LUMA_W    = 18;
	localparam int SUM_W     = 36;
	localparam int WCNT_W    = 25;
	localparam int CX_W      = 20;
	localparam int NORM_W    = 16;
	localparam int CX_FRAC   = 8;
	localparam int NORM_FRAC = 16;

	localparam int DVS_W     = WCNT_W + DIM_W;
	localparam int DVD_W     = SUM_W + NORM_FRAC;
	localparam int REM_W     = DVS_W;
	localparam int DIV_STEPS = 28;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [LUMA_W-1:0] LUMA_R   = LUMA_W'(299);
	localparam logic [LUMA_W-1:0] LUMA_G   = LUMA_W'(587);
	localparam logic [LUMA_W-1:0] LUMA_B   = LUMA_W'(114);
	localparam logic [LUMA_W-1:0] LUMA_DIV = LUMA_W'(1000);

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LUMA_THRESHOLD = 2'd2;

	localparam logic [DIM_W-1:0] RESET_WIDTH     = DIM_W'(640);
	localparam logic [DIM_W-1:0] RESET_HEIGHT    = DIM_W'(480);
	localparam logic [THR_W-1:0] RESET_THRESHOLD = THR_W'(240);

	typedef logic [1:0] op_t;
	localparam op_t OP_CX = 2'd0;
	localparam op_t OP_CY = 2'd1;
	localparam op_t OP_NX = 2'd2;
	localparam op_t OP_NY = 2'd3;

	typedef struct packed {
		logic accept;
		logic mul;
		logic div_load;
		logic div_step;
		logic q_store;
		op_t  op;
		logic out_load_frame;
	} ltc_cmd_t;

	typedef struct packed {
		logic frame_end;
		logic found;
	} ltc_sts_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> src/ltc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: pixel handshake, division sequencing, result register control.
module ltc_ctrl import ltc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pixel_valid,
	output logic     pixel_stall,
	output logic     result_valid,
	input  logic     result_stall,
	input  ltc_sts_t sts,
	output ltc_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_STEP  = 3'd3;
	localparam logic [2:0] S_STORE = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	op_t               op_q;
	logic              result_valid_q;

	logic accept;
	logic divide;
	logic out_free;
	logic fin_load;

	always_comb begin
		pixel_stall = (state_q != S_IDLE) || (result_valid_q && result_stall);
		accept      = pixel_valid && !pixel_stall;
		divide      = accept && sts.frame_end && sts.found;
		out_free    = !result_valid_q || !result_stall;
		fin_load    = (state_q == S_FIN) && out_free;

		cmd                = '0;
		cmd.accept         = accept;
		cmd.mul            = (state_q == S_MUL);
		cmd.div_load       = (state_q == S_LOAD);
		cmd.div_step       = (state_q == S_STEP);
		cmd.q_store        = (state_q == S_STORE);
		cmd.op             = op_q;
		cmd.out_load_frame = fin_load;
	end

	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((accept && !divide) || fin_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			op_q    <= OP_CX;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (divide) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					op_q    <= OP_CX;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					step_q  <= '0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_STORE;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_STORE: begin
					if (op_q == OP_NY) begin
						state_q <= S_FIN;
					end else begin
						op_q    <= op_q + 2'd1;
						state_q <= S_LOAD;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/ltc_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, luma threshold, accumulators, shared divider, result register.
module ltc_datapath import ltc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic [COLOR_W-1:0]   red,
	input  logic [COLOR_W-1:0]   green,
	input  logic [COLOR_W-1:0]   blue,
	input  ltc_cmd_t             cmd,
	output ltc_sts_t             sts,
	output logic                 white,
	output logic                 frame_done,
	output logic                 object_found,
	output logic [CX_W-1:0]      centroid_x,
	output logic [CX_W-1:0]      centroid_y,
	output logic [NORM_W-1:0]    norm_x,
	output logic [NORM_W-1:0]    norm_y
);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [THR_W-1:0]  thr_q;

	logic [POS_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;
	logic [SUM_W-1:0]  sx_q;
	logic [SUM_W-1:0]  sy_q;
	logic [WCNT_W-1:0] cnt_q;

	logic [SUM_W-1:0]  sx_hold_q;
	logic [SUM_W-1:0]  sy_hold_q;
	logic [WCNT_W-1:0] cnt_hold_q;
	logic              white_pend_q;
	logic [DVS_W-1:0]  prod_w_q;
	logic [DVS_W-1:0]  prod_h_q;

	logic [REM_W-1:0]     rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [CX_W-1:0]      cx_res_q;
	logic [CX_W-1:0]      cy_res_q;
	logic [NORM_W-1:0]    nx_res_q;
	logic [NORM_W-1:0]    ny_res_q;

	logic              white_q;
	logic              frame_done_q;
	logic              object_found_q;
	logic [CX_W-1:0]   centroid_x_q;
	logic [CX_W-1:0]   centroid_y_q;
	logic [NORM_W-1:0] norm_x_q;
	logic [NORM_W-1:0] norm_y_q;

	logic [DIM_W-1:0]  eff_w;
	logic [DIM_W-1:0]  eff_h;
	logic [POS_W-1:0]  last_x;
	logic [POS_W-1:0]  last_y;
	logic              last_col;
	logic              last_row;
	logic [LUMA_W-1:0] luma_sum;
	logic [LUMA_W-1:0] thr_scaled;
	logic              pix_white;
	logic [SUM_W-1:0]  sx_next;
	logic [SUM_W-1:0]  sy_next;
	logic [WCNT_W-1:0] cnt_next;
	logic [DVD_W-1:0]  dvd;
	logic [DVS_W-1:0]  dvs;
	logic [REM_W:0]    rem_sh;
	logic [REM_W+1:0]  diff;

	always_comb begin
		eff_w      = eff_dim(width_q);
		eff_h      = eff_dim(height_q);
		last_x     = POS_W'(eff_w - DIM_W'(1));
		last_y     = POS_W'(eff_h - DIM_W'(1));
		last_col   = col_q >= last_x;
		last_row   = row_q >= last_y;
		luma_sum   = LUMA_W'(red) * LUMA_R + LUMA_W'(green) * LUMA_G
			+ LUMA_W'(blue) * LUMA_B;
		thr_scaled = LUMA_W'(thr_q) * LUMA_DIV;
		pix_white  = luma_sum >= thr_scaled;
		sx_next    = pix_white ? sx_q + SUM_W'(col_q) : sx_q;
		sy_next    = pix_white ? sy_q + SUM_W'(row_q) : sy_q;
		cnt_next   = cnt_q + WCNT_W'(pix_white);

		sts.frame_end = last_col && last_row;
		sts.found     = cnt_next != '0;

		case (cmd.op)
			OP_CX: begin
				dvd = DVD_W'({sx_hold_q, CX_FRAC'(0)});
				dvs = DVS_W'(cnt_hold_q);
			end
			OP_CY: begin
				dvd = DVD_W'({sy_hold_q, CX_FRAC'(0)});
				dvs = DVS_W'(cnt_hold_q);
			end
			OP_NX: begin
				dvd = {sx_hold_q, NORM_FRAC'(0)};
				dvs = prod_w_q;
			end
			default: begin
				dvd = {sy_hold_q, NORM_FRAC'(0)};
				dvs = prod_h_q;
			end
		endcase

		rem_sh = {rem_q, quo_q[DIV_STEPS-1]};
		diff   = {1'b0, rem_sh} - (REM_W+2)'(dvs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			thr_q    <= RESET_THRESHOLD;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:    width_q  <= cfg_data;
				REG_FRAME_HEIGHT:   height_q <= cfg_data;
				REG_LUMA_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.accept) begin
			if (sts.frame_end) begin
				col_q <= '0;
				row_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
				cnt_q <= '0;
			end else begin
				sx_q  <= sx_next;
				sy_q  <= sy_next;
				cnt_q <= cnt_next;
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.frame_end) begin
			sx_hold_q    <= sx_next;
			sy_hold_q    <= sy_next;
			cnt_hold_q   <= cnt_next;
			white_pend_q <= pix_white;
		end
		if (cmd.mul) begin
			prod_w_q <= DVS_W'(cnt_hold_q) * DVS_W'(eff_w);
			prod_h_q <= DVS_W'(cnt_hold_q) * DVS_W'(eff_h);
		end
		if (cmd.div_load) begin
			rem_q <= REM_W'(dvd[DVD_W-1:DIV_STEPS]);
			quo_q <= dvd[DIV_STEPS-1:0];
		end else if (cmd.div_step) begin
			if (!diff[REM_W+1]) begin
				rem_q <= diff[REM_W-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[REM_W-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
			end
		end
		if (cmd.q_store) begin
			case (cmd.op)
				OP_CX:   cx_res_q <= quo_q[CX_W-1:0];
				OP_CY:   cy_res_q <= quo_q[CX_W-1:0];
				OP_NX:   nx_res_q <= quo_q[NORM_W-1:0];
				default: ny_res_q <= quo_q[NORM_W-1:0];
			endcase
		end
		if (cmd.out_load_frame) begin
			white_q        <= white_pend_q;
			frame_done_q   <= 1'b1;
			object_found_q <= 1'b1;
			centroid_x_q   <= cx_res_q;
			centroid_y_q   <= cy_res_q;
			norm_x_q       <= nx_res_q;
			norm_y_q       <= ny_res_q;
		end else if (cmd.accept && !(sts.frame_end && sts.found)) begin
			white_q        <= pix_white;
			frame_done_q   <= sts.frame_end;
			object_found_q <= 1'b0;
			centroid_x_q   <= '0;
			centroid_y_q   <= '0;
			norm_x_q       <= '0;
			norm_y_q       <= '0;
		end
	end

	assign white        = white_q;
	assign frame_done   = frame_done_q;
	assign object_found = object_found_q;
	assign centroid_x   = centroid_x_q;
	assign centroid_y   = centroid_y_q;
	assign norm_x       = norm_x_q;
	assign norm_y       = norm_y_q;

endmodule

>>> src/luma_threshold_centroid.sv
`timescale 1ns / 1ps
// A pixel that does not close a frame with white pixels yields its result in the cycle after
// its transaction; such pixels stream at one per cycle while result_stall does not hold the output.
// A frame's last pixel, when the frame held a white pixel, passes a multiply state, then four
// 28-step divisions on the one shared restoring divider (load, step, store each), then the result load.
// Reset: asynchronous; size 640 x 480, threshold 240, position and sums cleared at once.
module luma_threshold_centroid import ltc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic [COLOR_W-1:0]   red,
	input  logic [COLOR_W-1:0]   green,
	input  logic [COLOR_W-1:0]   blue,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 white,
	output logic                 frame_done,
	output logic                 object_found,
	output logic [CX_W-1:0]      centroid_x,
	output logic [CX_W-1:0]      centroid_y,
	output logic [NORM_W-1:0]    norm_x,
	output logic [NORM_W-1:0]    norm_y
);

	ltc_cmd_t cmd;
	ltc_sts_t sts;

	assign cfg_ready = 1'b1;

	ltc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	ltc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.cmd          (cmd),
		.sts          (sts),
		.white        (white),
		.frame_done   (frame_done),
		.object_found (object_found),
		.centroid_x   (centroid_x),
		.centroid_y   (centroid_y),
		.norm_x       (norm_x),
		.norm_y       (norm_y)
	);

endmodule

>>> tb/sv/luma_threshold_centroid_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for luma_threshold_centroid: table-driven and random pixel streams.
module luma_threshold_centroid_tb;
	import ltc_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned DRAIN_CYCLES = 130;
	localparam int unsigned RANDOM_PIXELS = 500;
	localparam int NUM_ROWS = 30;

	typedef struct packed {
		logic                white;
		logic                done;
		logic                found;
		logic [CX_W-1:0]     cx;
		logic [CX_W-1:0]     cy;
		logic [NORM_W-1:0]   nx;
		logic [NORM_W-1:0]   ny;
	} pixel_result_t;

	typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [REG_IDX_W-1:0] idx;
		logic [DIM_W-1:0]     data;
		logic [COLOR_W-1:0]   r;
		logic [COLOR_W-1:0]   g;
		logic [COLOR_W-1:0]   b;
		logic                 typed;
		logic                 t_white;
		logic                 t_done;
		logic                 t_found;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;
	logic                 pixel_valid = 1'b0;
	logic                 pixel_stall;
	logic [COLOR_W-1:0]   red = '0;
	logic [COLOR_W-1:0]   green = '0;
	logic [COLOR_W-1:0]   blue = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 white;
	logic                 frame_done;
	logic                 object_found;
	logic [CX_W-1:0]      centroid_x;
	logic [CX_W-1:0]      centroid_y;
	logic [NORM_W-1:0]    norm_x;
	logic [NORM_W-1:0]    norm_y;

	logic [DIM_W-1:0]     model_width = RESET_WIDTH;
	logic [DIM_W-1:0]     model_height = RESET_HEIGHT;
	logic [THR_W-1:0]     model_thr = RESET_THRESHOLD;
	int unsigned          col_pos = 0;
	int unsigned          row_pos = 0;
	longint unsigned      col_sum = 0;
	longint unsigned      row_sum = 0;
	longint unsigned      white_total = 0;

	pixel_result_t        pending_results[$];
	int unsigned          mismatches = 0;
	int unsigned          pixels_sent = 0;
	int unsigned          frames_closed = 0;
	int unsigned          frames_found = 0;
	int unsigned          cfg_writes = 0;
	int unsigned          cycle_count = 0;
	int unsigned          stall_left = 0;
	bit                   calm = 1'b0;

	stim_row_t directed [NUM_ROWS] = '{
		'{ROW_PIXEL, '0, '0,   0,   0,   0, 1, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 255, 255, 255, 1, 1, 0, 0},
		'{ROW_PIXEL, '0, '0, 255,   0,   0, 1, 0, 0, 0},
		'{ROW_PIXEL, '0, '0,   0, 255,   0, 1, 0, 0, 0},
		'{ROW_PIXEL, '0, '0,   0,   0, 255, 1, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 240, 240, 240, 1, 1, 0, 0},
		'{ROW_PIXEL, '0, '0, 239, 239, 239, 1, 0, 0, 0},
		'{ROW_CFG, REG_FRAME_WIDTH, 1, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 1, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 255, 255, 255, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 255, 255, 255, 1, 1, 1, 1},
		'{ROW_PIXEL, '0, '0,   0,   0,   0, 1, 0, 1, 0},
		'{ROW_CFG, REG_LUMA_THRESHOLD, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0,   0,   0,   0, 1, 1, 1, 1},
		'{ROW_CFG, REG_LUMA_THRESHOLD, 13'h1FFF, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 255, 255, 255, 1, 1, 1, 1},
		'{ROW_PIXEL, '0, '0, 254, 255, 255, 1, 0, 1, 0},
		'{ROW_CFG, REG_UNUSED, 13'h1555, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 254, 255, 255, 1, 0, 1, 0},
		'{ROW_CFG, REG_FRAME_WIDTH, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 3, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_LUMA_THRESHOLD, 100, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 170,  85, 200, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0,  10,  20,  30, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 200, 200,   0, 0, 0, 0, 0},
		'{ROW_CFG, REG_FRAME_WIDTH, 3, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 128, 128, 128, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0,  90, 200,  17, 0, 0, 0, 0},
		'{ROW_PIXEL, '0, '0, 255, 255,   0, 0, 0, 0, 0}
	};

	luma_threshold_centroid u_top (.*);

	always #10 clk = ~clk;

	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			return $urandom_range(1, 2);
		end else if (pick < 19) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [DIM_W-1:0] pick_size(input int unsigned usual_max);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return DIM_W'(MAX_DIM);
			3: return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
			default: return DIM_W'($urandom_range(1, usual_max));
		endcase
	endfunction

	function automatic pixel_result_t predict_pixel(input logic [COLOR_W-1:0] r, g, b);
		pixel_result_t res;
		int unsigned w;
		int unsigned h;
		int unsigned luma;
		logic last_col;
		logic last_row;
		w = (model_width == '0) ? 1 : (model_width > MAX_DIM) ? MAX_DIM : model_width;
		h = (model_height == '0) ? 1 : (model_height > MAX_DIM) ? MAX_DIM : model_height;
		luma = (32'd299 * r + 32'd587 * g + 32'd114 * b) / 32'd1000;
		res = '0;
		res.white = luma >= model_thr;
		last_col = col_pos >= w - 1;
		last_row = row_pos >= h - 1;
		if (res.white) begin
			col_sum += col_pos;
			row_sum += row_pos;
			white_total += 1;
		end
		if (last_col && last_row) begin
			res.done = 1'b1;
			if (white_total != 0) begin
				res.found = 1'b1;
				res.cx = CX_W'((col_sum << 8) / white_total);
				res.cy = CX_W'((row_sum << 8) / white_total);
				res.nx = NORM_W'((col_sum << 16) / (white_total * w));
				res.ny = NORM_W'((row_sum << 16) / (white_total * h));
			end
			col_pos = 0;
			row_pos = 0;
			col_sum = 0;
			row_sum = 0;
			white_total = 0;
		end else if (last_col) begin
			col_pos = 0;
			row_pos += 1;
		end else begin
			col_pos += 1;
		end
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [CX_W-1:0] want,
			input logic [CX_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: model_width = data;
			REG_FRAME_HEIGHT: model_height = data;
			REG_LUMA_THRESHOLD: model_thr = data[THR_W-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic send_pixel(input logic [COLOR_W-1:0] r, g, b, input logic use_typed,
			input pixel_result_t typed_res);
		int unsigned gap;
		pixel_result_t want;
		gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : idle_len());
		if (gap != 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (pixel_stall);
		want = predict_pixel(r, g, b);
		frames_closed += want.done;
		frames_found += want.found;
		pending_results.push_back(use_typed ? typed_res : want);
		pixels_sent++;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			stall_left <= idle_len() - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no pixel pending", $time);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("white", want.white, white);
				check_field("frame_done", want.done, frame_done);
				check_field("object_found", want.found, object_found);
				check_field("centroid_x", want.cx, centroid_x);
				check_field("centroid_y", want.cy, centroid_y);
				check_field("norm_x", want.nx, norm_x);
				check_field("norm_y", want.ny, norm_y);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("luma_threshold_centroid_tb NOT OK");
			$finish;
		end
	end

	initial begin
		pixel_result_t typed_res;
		int unsigned random_pixels;
		int unsigned burst;
		int unsigned style;
		int level;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		random_pixels = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				wait_idle();
				cfg_write(directed[i].idx, directed[i].data);
			end else begin
				typed_res = '0;
				typed_res.white = directed[i].t_white;
				typed_res.done = directed[i].t_done;
				typed_res.found = directed[i].t_found;
				send_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].typed,
					typed_res);
			end
		end

		while (random_pixels < RANDOM_PIXELS) begin
			wait_idle();
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1)) cfg_write(REG_FRAME_WIDTH, pick_size(8));
			if ($urandom_range(0, 1)) cfg_write(REG_FRAME_HEIGHT, pick_size(6));
			if ($urandom_range(0, 1)) begin
				cfg_write(REG_LUMA_THRESHOLD,
					{5'($urandom_range(0, 31)), 8'($urandom_range(0, 255))});
			end
			if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED, DIM_W'($urandom));
			burst = $urandom_range(1, 40);
			style = $urandom_range(0, 2);
			repeat (burst) begin
				case (style)
					0: begin
						r = 8'($urandom_range(0, 255));
						g = 8'($urandom_range(0, 255));
						b = 8'($urandom_range(0, 255));
					end
					1: begin
						level = int'(model_thr) + int'($urandom_range(0, 4)) - 2;
						if (level < 0) level = 0;
						if (level > 255) level = 255;
						r = 8'(level);
						g = 8'(level);
						b = 8'(level);
					end
					default: begin
						r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
						g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
						b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					end
				endcase
				send_pixel(r, g, b, 1'b0, typed_res);
				random_pixels++;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("streamed %0d pixels over %0d closed frames, %0d of them with white pixels",
			pixels_sent, frames_closed, frames_found);
		$display("%0d register writes incl. odd sizes and thresholds; %0d mismatches",
			cfg_writes, mismatches);
		if (mismatches == 0) begin
			$display("luma_threshold_centroid_tb OK");
		end else begin
			$display("luma_threshold_centroid_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> files.f
src/ltc_pkg.sv
src/ltc_ctrl.sv
src/ltc_datapath.sv
src/luma_threshold_centroid.sv
tb/sv/luma_threshold_centroid_tb.sv
